// File: hdl/mla_pkg.sv
// Shared types and codes of the masked linear argmax scorer.
package mla_pkg;

    localparam int VALUE_W  = 32;
    localparam int SLOT_W   = 9;
    localparam int MASK_W   = 8;
    localparam int WEIGHT_W = 16;
    localparam int SCORE_W  = 38;
    localparam int ACTION_W = 3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int FC_RAW_W    = 7;
    localparam int AC_RAW_W    = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_VECTOR_LEN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTION_COUNT = 2'd1;

    localparam logic [1:0] REQ_WEIGHT  = 2'd0;
    localparam logic [1:0] REQ_BIAS    = 2'd1;
    localparam logic [1:0] REQ_FEATURE = 2'd2;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_LEGAL = 1'b1;

    typedef enum logic [1:0] {
        OP_WEIGHT,
        OP_BIAS,
        OP_FEATURE
    } t_op;

    // One classified command from the front to the back.
    typedef struct packed {
        t_op                op;
        logic [SLOT_W-1:0]  idx;
        logic [VALUE_W-1:0] data;
        logic               first;
        logic               last;
        logic [MASK_W-1:0]  mask;
    } t_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [SCORE_W-1:0] score;
        logic                      status;
    } t_result;

endpackage

// File: hdl/masked_linear_argmax_top.sv
// Masked linear argmax scorer: configuration, queues and the front and back ends.
//
// Usage: load weights (type 0, slot action*vector_len+feature) and biases
// (type 1, slot action) through the request queue, then stream feature samples
// (type 2). Every vector_len samples (register 0) one result appears on the result
// queue: the legal action with the highest score, lowest index on ties, where the
// mask comes from the final sample; an empty mask gives status 1 with zeros.
// Requests: push/full, a transaction happens when push is high and full is low.
// Results: empty/pop, the oldest result shows while empty is low and leaves when
// pop is high. Configuration: i_cfg_valid/o_cfg_ready, always ready; write it
// only while the block is idle.
// Structure: a four-entry command queue separates the front end from the back end.
// The back end writes a weight or bias while idle and scores one feature sample
// at a time, taking no new command until that sample is done, with the single
// multiply-accumulate unit that visits the scored actions in turn.
// A result is pushed from the finish state once the final sample's actions are compared.
// Reset clears the queues, the sample position and the scores, and sets both
// counts to one; the stores are undefined until written. When the result queue
// is full, a final sample waits in the command queue and requests back up to full.
module masked_linear_argmax_top #(
    parameter int MAX_FEATURES = 64,
    parameter int MAX_ACTIONS  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [1:0]                            i_req_type,
    input  logic [mla_pkg::SLOT_W-1:0]            i_slot,
    input  logic signed [mla_pkg::VALUE_W-1:0]    i_value,
    input  logic [mla_pkg::MASK_W-1:0]            i_legal_mask,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [mla_pkg::ACTION_W-1:0]          o_chosen_action,
    output logic signed [mla_pkg::SCORE_W-1:0]    o_best_score,
    output logic                                  o_status,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mla_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [mla_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int CW   = $clog2(MAX_FEATURES + 1);
    localparam int NACT = (MAX_ACTIONS < 8) ? MAX_ACTIONS : 8;
    localparam int NAW  = $clog2(NACT + 1);

    logic [mla_pkg::FC_RAW_W-1:0] r_fc_raw;
    logic [mla_pkg::AC_RAW_W-1:0] r_ac_raw;
    logic [CW-1:0]                fc;
    logic [NAW-1:0]               nact;

    logic                         q_push;
    logic                         q_full;
    logic                         q_empty;
    logic                         q_pop;
    mla_pkg::t_cmd                q_in;
    mla_pkg::t_cmd                q_out;
    logic                         res_push;
    logic                         res_full;
    mla_pkg::t_result             res_in;
    mla_pkg::t_result             res_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc_raw <= mla_pkg::FC_RAW_W'(1);
            r_ac_raw <= mla_pkg::AC_RAW_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mla_pkg::CFG_VECTOR_LEN:   r_fc_raw <= i_cfg_data[mla_pkg::FC_RAW_W-1:0];
                mla_pkg::CFG_ACTION_COUNT: r_ac_raw <= i_cfg_data[mla_pkg::AC_RAW_W-1:0];
                default: ;
            endcase
        end
    end

    // A count of zero acts as one; larger counts are limited to the store size.
    always_comb begin
        if (r_fc_raw == '0) begin
            fc = CW'(1);
        end else if (int'(r_fc_raw) > MAX_FEATURES) begin
            fc = CW'(MAX_FEATURES);
        end else begin
            fc = CW'(r_fc_raw);
        end
        if (r_ac_raw == '0) begin
            nact = NAW'(1);
        end else if (int'(r_ac_raw) > NACT) begin
            nact = NAW'(NACT);
        end else begin
            nact = NAW'(r_ac_raw);
        end
    end

    mla_front #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_ACTIONS  (MAX_ACTIONS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_req_type   (i_req_type),
        .i_slot       (i_slot),
        .i_value      (i_value),
        .i_legal_mask (i_legal_mask),
        .i_fc         (fc),
        .i_q_full     (q_full),
        .o_full       (full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in)
    );

    mla_fifo #(
        .WIDTH ($bits(mla_pkg::t_cmd)),
        .DEPTH (4)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    mla_back #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_ACTIONS  (MAX_ACTIONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .i_fc        (fc),
        .i_nact      (nact),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    mla_fifo #(
        .WIDTH ($bits(mla_pkg::t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_chosen_action = res_out.action;
    assign o_best_score    = res_out.score;
    assign o_status        = res_out.status;

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full result queue");

    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command taken from an empty queue");

    a_no_legal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == mla_pkg::STATUS_NO_LEGAL))
        |-> ((o_best_score == '0) && (o_chosen_action == '0)))
        else $error("no-legal result carries a nonzero action or score");

    a_push_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> $past(q_pop, 1) == 1'b0)
        else $error("result pushed right after a command was taken");

endmodule

// File: hdl/mla_fifo.sv
// Small register queue used for the command path and the result path.
module mla_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_rd;
    logic [PW-1:0]    r_wr;
    logic [CNTW-1:0]  r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr] <= i_data;
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

endmodule

// File: hdl/mla_front.sv
// Front end: accepts requests, drops ignored ones and tracks the sample position.
module mla_front #(
    parameter int MAX_FEATURES = 64,
    parameter int MAX_ACTIONS  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic [1:0]                            i_req_type,
    input  logic [mla_pkg::SLOT_W-1:0]            i_slot,
    input  logic signed [mla_pkg::VALUE_W-1:0]    i_value,
    input  logic [mla_pkg::MASK_W-1:0]            i_legal_mask,
    input  logic [$clog2(MAX_FEATURES + 1)-1:0]   i_fc,
    input  logic                                  i_q_full,
    output logic                                  o_full,
    output logic                                  o_q_push,
    output mla_pkg::t_cmd                         o_q_cmd
);

    localparam int WDEPTH = MAX_FEATURES * MAX_ACTIONS;
    localparam int NACT   = (MAX_ACTIONS < 8) ? MAX_ACTIONS : 8;
    localparam int CW     = $clog2(MAX_FEATURES + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] cnt_eff;
    logic          is_last;
    logic          accept;
    logic          keep;

    assign o_full  = i_q_full;
    assign accept  = i_push && !i_q_full;
    // A count that shrank below the current position restarts the vector.
    assign cnt_eff = (r_cnt >= i_fc) ? '0 : r_cnt;
    assign is_last = ((cnt_eff + CW'(1)) >= i_fc);

    always_comb begin
        o_q_cmd.idx   = i_slot;
        o_q_cmd.data  = i_value;
        o_q_cmd.first = 1'b0;
        o_q_cmd.last  = 1'b0;
        o_q_cmd.mask  = i_legal_mask;
        o_q_cmd.op    = mla_pkg::OP_WEIGHT;
        keep          = 1'b0;
        unique case (i_req_type)
            mla_pkg::REQ_WEIGHT: begin
                o_q_cmd.op = mla_pkg::OP_WEIGHT;
                keep       = (int'(i_slot) < WDEPTH);
            end
            mla_pkg::REQ_BIAS: begin
                o_q_cmd.op = mla_pkg::OP_BIAS;
                keep       = (int'(i_slot) < NACT);
            end
            mla_pkg::REQ_FEATURE: begin
                o_q_cmd.op    = mla_pkg::OP_FEATURE;
                o_q_cmd.idx   = mla_pkg::SLOT_W'(cnt_eff);
                o_q_cmd.first = (cnt_eff == '0);
                o_q_cmd.last  = is_last;
                keep          = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_q_push = accept && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept && (i_req_type == mla_pkg::REQ_FEATURE)) begin
            r_cnt <= is_last ? '0 : cnt_eff + CW'(1);
        end
    end

endmodule

// File: hdl/mla_back.sv
// Back end: weight and bias stores, shared multiply-accumulate and running argmax.
module mla_back #(
    parameter int MAX_FEATURES = 64,
    parameter int MAX_ACTIONS  = 8
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_cmd_valid,
    input  mla_pkg::t_cmd                                         i_cmd,
    output logic                                                  o_cmd_pop,
    input  logic [$clog2(MAX_FEATURES + 1)-1:0]                   i_fc,
    input  logic [$clog2(((MAX_ACTIONS < 8) ? MAX_ACTIONS : 8) + 1)-1:0] i_nact,
    input  logic                                                  i_res_full,
    output logic                                                  o_res_push,
    output mla_pkg::t_result                                      o_res
);

    localparam int WDEPTH = MAX_FEATURES * MAX_ACTIONS;
    localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int NACT   = (MAX_ACTIONS < 8) ? MAX_ACTIONS : 8;
    localparam int AW     = (NACT > 1) ? $clog2(NACT) : 1;
    localparam int NAW    = $clog2(NACT + 1);
    localparam int SW     = mla_pkg::SCORE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    t_state r_state;

    logic [mla_pkg::WEIGHT_W-1:0]       r_wmem [WDEPTH];
    logic signed [mla_pkg::WEIGHT_W-1:0] r_w;
    logic [mla_pkg::VALUE_W-1:0]        r_bias [NACT];
    logic [SW-1:0]                      r_acc  [NACT];

    logic signed [mla_pkg::WEIGHT_W-1:0] r_feat;
    logic                               r_last;
    logic [mla_pkg::MASK_W-1:0]         r_mask;
    logic [WA-1:0]                      r_addr;
    logic [AW-1:0]                      r_issue_a;
    logic [NAW-1:0]                     r_left;

    logic                               r_s1_v;
    logic [AW-1:0]                      r_s1_a;
    logic                               r_s2_v;
    logic [AW-1:0]                      r_s2_a;
    logic signed [31:0]                 r_prod;
    logic                               r_s3_v;
    logic [AW-1:0]                      r_s3_a;
    logic [SW-1:0]                      r_sum;

    logic                               r_found;
    logic [SW-1:0]                      r_best;
    logic [AW-1:0]                      r_best_a;

    logic                               start_feat;
    logic                               wr_weight;
    logic                               issue;
    logic                               take_best;
    logic [SW-1:0]                      n_sum;

    assign wr_weight  = (r_state == S_IDLE) && i_cmd_valid
                        && (i_cmd.op == mla_pkg::OP_WEIGHT);
    // A final sample waits until the result queue can take its result.
    assign start_feat = (r_state == S_IDLE) && i_cmd_valid
                        && (i_cmd.op == mla_pkg::OP_FEATURE)
                        && (!i_cmd.last || !i_res_full);
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid
                        && ((i_cmd.op != mla_pkg::OP_FEATURE) || start_feat);
    assign issue      = (r_state == S_RUN) && (r_left != '0);
    assign n_sum      = r_acc[r_s2_a] + {{(SW - 32){r_prod[31]}}, r_prod};
    assign take_best  = r_s3_v && r_last && r_mask[r_s3_a]
                        && (!r_found || ($signed(r_sum) > $signed(r_best)));

    always_ff @(posedge i_clk) begin
        if (wr_weight) begin
            r_wmem[WA'(i_cmd.idx)] <= i_cmd.data[mla_pkg::WEIGHT_W-1:0];
        end
        if (issue) begin
            r_w <= r_wmem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_found <= 1'b0;
            for (int i = 0; i < NACT; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_s1_v <= issue;
            r_s1_a <= r_issue_a;
            r_s2_v <= r_s1_v;
            r_s2_a <= r_s1_a;
            r_prod <= r_w * r_feat;
            r_s3_v <= r_s2_v;
            r_s3_a <= r_s2_a;
            if (r_s2_v) begin
                r_acc[r_s2_a] <= n_sum;
                r_sum         <= n_sum;
            end
            if (take_best) begin
                r_found  <= 1'b1;
                r_best   <= r_sum;
                r_best_a <= r_s3_a;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && (i_cmd.op == mla_pkg::OP_BIAS)) begin
                        r_bias[i_cmd.idx[AW-1:0]] <= i_cmd.data;
                    end
                    if (start_feat) begin
                        if (i_cmd.first) begin
                            for (int i = 0; i < NACT; i++) begin
                                r_acc[i] <= {{(SW - 32){r_bias[i][31]}}, r_bias[i]};
                            end
                        end
                        r_feat    <= i_cmd.data[mla_pkg::WEIGHT_W-1:0];
                        r_last    <= i_cmd.last;
                        r_mask    <= i_cmd.mask;
                        r_addr    <= WA'(i_cmd.idx);
                        r_issue_a <= '0;
                        r_left    <= i_nact;
                        r_found   <= 1'b0;
                        r_state   <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (issue) begin
                        r_addr    <= r_addr + WA'(i_fc);
                        r_issue_a <= r_issue_a + AW'(1);
                        r_left    <= r_left - NAW'(1);
                    end
                    if (r_s3_v && (r_s3_a == AW'(i_nact - NAW'(1)))) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_push   = (r_state == S_FIN) && r_last;
    assign o_res.action = r_found ? mla_pkg::ACTION_W'(r_best_a) : '0;
    assign o_res.score  = r_found ? r_best : '0;
    assign o_res.status = r_found ? mla_pkg::STATUS_OK : mla_pkg::STATUS_NO_LEGAL;

endmodule
